// File: rtl/core/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// shared constants, register codes and field widths of the stick to cursor block
// ----------------------------------------------------------------------------
package stc_pkg;

    // fraction bits of the fixed point factors
    localparam int FRAC_BITS_DEF = 8;

    // field widths
    localparam int AXIS_W   = 16;
    localparam int DELTA_W  = AXIS_W + 1;
    localparam int TRIG_W   = 8;
    localparam int DZ_W     = 15;
    localparam int CTL_W    = 6;
    localparam int MAXF_W   = 14;
    localparam int SPEED_W  = 16;
    localparam int SCREEN_W = 14;
    localparam int SQ_W     = 2 * AXIS_W;

    // configuration port
    localparam int CFG_W = 16;
    localparam int IDX_W = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_DEADZONE     = 3'd2,
        REG_CONTROL      = 3'd3,
        REG_ACC_PEAK     = 3'd4,
        REG_BRAKE_MAX    = 3'd5,
        REG_GAIN         = 3'd6,
        REG_SCREEN_WIDTH = 3'd7
    } t_reg_idx;

    // control register fields
    localparam int CTL_LROLE_LSB = 0;
    localparam int CTL_RROLE_LSB = 2;
    localparam int CTL_EXP       = 4;
    localparam int CTL_ON        = 5;

    localparam logic [1:0] ROLE_ACCEL = 2'd1;
    localparam logic [1:0] ROLE_BRAKE = 2'd2;

    // reset values
    localparam logic [AXIS_W-1:0]   CENTER_RST       = '0;
    localparam logic [DZ_W-1:0]     DEADZONE_RST     = '0;
    localparam logic [CTL_W-1:0]    CONTROL_RST      = 6'd32;
    localparam logic [MAXF_W-1:0]   ACC_PEAK_RST     = 14'd256;
    localparam logic [MAXF_W-1:0]   BRAKE_MAX_RST    = 14'd256;
    localparam logic [SPEED_W-1:0]  GAIN_RST         = 16'd256;
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST = 14'd1920;

    // trigger full scale
    localparam logic [TRIG_W-1:0] TRIG_FULL = 8'd255;

    // exponent of the power curve: t * 65536 / 255 equals t * 257 below full scale
    localparam int N_ROOTS = 16;
    localparam logic [N_ROOTS-1:0] EXP_STEP = 16'd257;
    localparam int Q_INT = 20;

    // floor(v / 255) as (v * DIV255_MUL) >> DIV255_SHIFT, exact for v below 2^25
    localparam int DIV255_W     = 27;
    localparam int DIV255_SHIFT = 34;
    localparam logic [DIV255_W-1:0] DIV255_MUL = 27'd67372037;

    // quotient bits kept before saturation
    localparam int QUOT_BITS = 17;

endpackage
`default_nettype wire

// File: rtl/core/stc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_if
// request channels of the stick to cursor block: stick samples in, moves out
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic        [7:0]  trig_l;
    logic        [7:0]  trig_r;

    modport source (output valid, output stick_x, output stick_y,
                    output trig_l, output trig_r, input ready);
    modport sink   (input valid, input stick_x, input stick_y,
                    input trig_l, input trig_r, output ready);
endinterface

interface stc_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;

    modport source (output valid, output move_x, output move_y, input ready);
    modport sink   (input valid, input move_x, input move_y, output ready);
endinterface
`default_nettype wire

// File: rtl/core/stc_roots.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_roots
// repeated square roots of the accel maximum, one result bit per cycle
// ----------------------------------------------------------------------------
module stc_roots #(
    parameter int FRAC_BITS = stc_pkg::FRAC_BITS_DEF,
    parameter int AMW       = 14,
    parameter int RW        = 26
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [AMW-1:0]                    i_amax,
    output logic                              o_busy,
    output logic [stc_pkg::N_ROOTS-1:0][RW-1:0] o_roots
);
    import stc_pkg::*;

    localparam int SW = (RW + Q_INT + 1) / 2;
    localparam int VW = 2 * SW;
    localparam int CW = (SW > 1) ? $clog2(SW) : 1;
    localparam int KW = $clog2(N_ROOTS);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_INIT, ST_STEP} t_state;

    t_state            r_state;
    logic [RW-1:0]     r_cur;
    logic [VW-1:0]     r_rem;
    logic [VW-1:0]     r_res;
    logic [VW-1:0]     r_bit;
    logic [CW-1:0]     r_step;
    logic [KW-1:0]     r_k;
    logic [N_ROOTS-1:0][RW-1:0] r_roots;

    logic [VW-1:0]     w_trial;
    logic              w_take;

    assign w_trial = r_res + r_bit;
    assign w_take  = (r_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_k     <= '0;
        end else if (i_start) begin
            r_state <= ST_LOAD;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_LOAD: begin
                    r_cur   <= RW'(i_amax) << (Q_INT - FRAC_BITS);
                    r_k     <= '0;
                    r_state <= ST_INIT;
                end
                ST_INIT: begin
                    r_rem   <= VW'({r_cur, {Q_INT{1'b0}}});
                    r_res   <= '0;
                    r_bit   <= VW'(1) << (VW - 2);
                    r_step  <= '0;
                    r_state <= ST_STEP;
                end
                ST_STEP: begin
                    if (w_take) begin
                        r_rem <= r_rem - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + CW'(1);
                    if (r_step == CW'(SW - 1)) begin
                        if (r_k != KW'(N_ROOTS - 1)) begin
                            r_state <= ST_INIT;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // root done: store it and start the next one from it
            if (r_state == ST_STEP && r_step == CW'(SW - 1)) begin
                if (w_take) begin
                    r_roots[r_k] <= RW'((r_res >> 1) + r_bit);
                    r_cur        <= RW'((r_res >> 1) + r_bit);
                end else begin
                    r_roots[r_k] <= RW'(r_res >> 1);
                    r_cur        <= RW'(r_res >> 1);
                end
                if (r_k != KW'(N_ROOTS - 1)) begin
                    r_k <= r_k + KW'(1);
                end
            end
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_roots = r_roots;

endmodule
`default_nettype wire

// File: rtl/core/stc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_div
// pipelined signed divide of both axes by a shared divisor, with saturation
// ----------------------------------------------------------------------------
module stc_div #(
    parameter int NW = 47,
    parameter int DW = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num_x,
    input  logic signed [NW-1:0] i_num_y,
    input  logic [DW-1:0]        i_den,
    output logic                 o_valid,
    output logic signed [15:0]   o_move_x,
    output logic signed [15:0]   o_move_y
);
    import stc_pkg::*;

    localparam int MW  = NW - 1;
    localparam int RMW = DW + QUOT_BITS;

    typedef struct packed {
        logic          valid;
        logic          neg_x;
        logic          neg_y;
        logic [MW-1:0] mag_x;
        logic [MW-1:0] mag_y;
        logic [DW-1:0] den;
    } t_abs;

    typedef struct packed {
        logic                 valid;
        logic                 ovf_x;
        logic                 ovf_y;
        logic                 neg_x;
        logic                 neg_y;
        logic [RMW-1:0]       rem_x;
        logic [RMW-1:0]       rem_y;
        logic [QUOT_BITS-1:0] q_x;
        logic [QUOT_BITS-1:0] q_y;
        logic [DW-1:0]        den;
    } t_step;

    function automatic logic [15:0] sat_q(logic ovf, logic neg, logic [QUOT_BITS-1:0] q);
        logic [QUOT_BITS-1:0] lim_pos;
        logic [QUOT_BITS-1:0] lim_neg;
        lim_pos = QUOT_BITS'(16'h7fff);
        lim_neg = QUOT_BITS'(17'h08000);
        if (neg) begin
            if (ovf || q > lim_neg) begin
                sat_q = 16'h8000;
            end else begin
                sat_q = 16'(QUOT_BITS'(0) - q);
            end
        end else begin
            if (ovf || q > lim_pos) begin
                sat_q = 16'h7fff;
            end else begin
                sat_q = q[15:0];
            end
        end
    endfunction

    t_abs  r_a;
    t_step r_st [0:QUOT_BITS];
    logic               r_valid;
    logic signed [15:0] r_move_x;
    logic signed [15:0] r_move_y;

    // magnitudes; the y result is negated, so its sign flips
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (i_en) begin
            r_a.valid <= i_valid;
            r_a.neg_x <= i_num_x[NW-1];
            r_a.neg_y <= !i_num_y[NW-1];
            r_a.mag_x <= i_num_x[NW-1] ? MW'(-i_num_x) : MW'(i_num_x);
            r_a.mag_y <= i_num_y[NW-1] ? MW'(-i_num_y) : MW'(i_num_y);
            r_a.den   <= i_den;
        end
    end

    // quotient too big for the kept bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else if (i_en) begin
            r_st[0].valid <= r_a.valid;
            r_st[0].ovf_x <= (r_a.mag_x >= (MW'(r_a.den) << QUOT_BITS));
            r_st[0].ovf_y <= (r_a.mag_y >= (MW'(r_a.den) << QUOT_BITS));
            r_st[0].neg_x <= r_a.neg_x;
            r_st[0].neg_y <= r_a.neg_y;
            r_st[0].rem_x <= RMW'(r_a.mag_x);
            r_st[0].rem_y <= RMW'(r_a.mag_y);
            r_st[0].q_x   <= '0;
            r_st[0].q_y   <= '0;
            r_st[0].den   <= r_a.den;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar s = 0; s < QUOT_BITS; s++) begin : g_step
        localparam int SH = QUOT_BITS - 1 - s;
        logic [RMW-1:0] w_dsh;
        t_step          w_nxt;

        assign w_dsh = RMW'(r_st[s].den) << SH;

        always_comb begin
            w_nxt = r_st[s];
            if (r_st[s].rem_x >= w_dsh) begin
                w_nxt.rem_x    = r_st[s].rem_x - w_dsh;
                w_nxt.q_x[SH]  = 1'b1;
            end
            if (r_st[s].rem_y >= w_dsh) begin
                w_nxt.rem_y    = r_st[s].rem_y - w_dsh;
                w_nxt.q_y[SH]  = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[s+1].valid <= 1'b0;
            end else if (i_en) begin
                r_st[s+1] <= w_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= r_st[QUOT_BITS].valid;
            r_move_x <= sat_q(r_st[QUOT_BITS].ovf_x, r_st[QUOT_BITS].neg_x,
                              r_st[QUOT_BITS].q_x);
            r_move_y <= sat_q(r_st[QUOT_BITS].ovf_y, r_st[QUOT_BITS].neg_y,
                              r_st[QUOT_BITS].q_y);
        end
    end

    assign o_valid  = r_valid;
    assign o_move_x = r_move_x;
    assign o_move_y = r_move_y;

endmodule
`default_nettype wire

// File: rtl/core/stick_to_cursor_delta.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stick_to_cursor_delta
// analogue stick sample plus triggers to a relative cursor move
// ----------------------------------------------------------------------------
// usage
//   i_in carries one stick sample and both trigger bytes per request; o_out
//   carries one (move_x, move_y) request per sample outside the dead zone
//   while cursor mode is on, other samples leave no result
//   registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle, one register per write
//   throughput: one request per cycle while neither a stall nor a root pass
//   holds the input; the pipeline holds the 16 multiply stages of the power
//   curve and the 17 stages of the quotient
//   reset: registers take their default values and the block computes the
//   16 repeated roots of the accel peak, with i_in.ready low; every write of
//   the accel peak starts that pass again
//   stall: when o_out holds a request that is not taken, the whole pipeline
//   holds and i_in.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module stick_to_cursor_delta #(
    parameter int FRAC_BITS = stc_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [stc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [stc_pkg::CFG_W-1:0]   i_cfg_data,
    stc_in_if.sink                      i_in,
    stc_out_if.source                   o_out
);
    import stc_pkg::*;

    // factor width: the 14 bit maxima, or wide enough for 1.0 itself
    localparam int AMW = (FRAC_BITS + 1 > MAXF_W) ? FRAC_BITS + 1 : MAXF_W;
    localparam int RW  = AMW + Q_INT - FRAC_BITS;
    localparam int LPW = TRIG_W + AMW;
    localparam int LMW = LPW + DIV255_W;
    localparam int DW  = SCREEN_W + AMW;
    localparam int BW  = SPEED_W + DELTA_W;
    localparam int NW  = BW + AMW;
    localparam logic [AMW-1:0] ONE_A = AMW'(1) << FRAC_BITS;

    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] x;
        logic signed [DELTA_W-1:0] y;
        logic [TRIG_W-1:0]         t;
        logic [TRIG_W-1:0]         b;
    } t_s0;

    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] x;
        logic signed [DELTA_W-1:0] y;
        logic [TRIG_W-1:0]         t;
        logic [SQ_W-1:0]           xx;
        logic [SQ_W-1:0]           yy;
        logic [LPW-1:0]            lin_p;
        logic [LPW-1:0]            brk_p;
    } t_s1;

    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] x;
        logic signed [DELTA_W-1:0] y;
        logic [TRIG_W-1:0]         t;
        logic [LMW-1:0]            lin_m;
        logic [LMW-1:0]            brk_m;
    } t_s2;

    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] x;
        logic signed [DELTA_W-1:0] y;
        logic [N_ROOTS-1:0]        e;
        logic                      tz;
        logic                      tf;
        logic [AMW-1:0]            lin;
        logic [AMW-1:0]            brk;
        logic [RW-1:0]             acc;
    } t_ex;

    typedef struct packed {
        logic                 valid;
        logic signed [BW-1:0] bx;
        logic signed [BW-1:0] by;
        logic [AMW-1:0]       accel;
        logic [DW-1:0]        den;
    } t_m1;

    typedef struct packed {
        logic                 valid;
        logic signed [NW-1:0] num_x;
        logic signed [NW-1:0] num_y;
        logic [DW-1:0]        den;
    } t_m2;

    // configuration registers
    logic [AXIS_W-1:0]   r_center_x;
    logic [AXIS_W-1:0]   r_center_y;
    logic [DZ_W-1:0]     r_deadzone;
    logic [CTL_W-1:0]    r_control;
    logic [MAXF_W-1:0]   r_acc_peak;
    logic [MAXF_W-1:0]   r_brake_max;
    logic [SPEED_W-1:0]  r_gain;
    logic [SCREEN_W-1:0] r_screen_width;
    logic [2*DZ_W-1:0]   r_dz2;

    // pipeline stages
    t_s0 r_s0;
    t_s1 r_s1;
    t_s2 r_s2;
    t_ex r_ex [0:N_ROOTS];
    t_m1 r_m1;
    t_m2 r_m2;

    logic                        w_en;
    logic                        w_amax_wr;
    logic                        w_roots_busy;
    logic [N_ROOTS-1:0][RW-1:0]  w_roots;
    logic [AMW-1:0]              w_amax;
    logic [AMW-1:0]              w_bmax;
    logic [SCREEN_W-1:0]         w_width;
    logic [1:0]                  w_lrole;
    logic [1:0]                  w_rrole;
    logic [TRIG_W-1:0]           w_t;
    logic [TRIG_W-1:0]           w_b;
    logic                        w_out_valid;
    logic [AMW-1:0]              w_accel;

    // ---------------------------------------------------------------- config
    assign w_amax_wr = i_cfg_we && (t_reg_idx'(i_cfg_idx) == REG_ACC_PEAK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x     <= CENTER_RST;
            r_center_y     <= CENTER_RST;
            r_deadzone     <= DEADZONE_RST;
            r_control      <= CONTROL_RST;
            r_acc_peak     <= ACC_PEAK_RST;
            r_brake_max    <= BRAKE_MAX_RST;
            r_gain         <= GAIN_RST;
            r_screen_width <= SCREEN_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_X:     r_center_x     <= i_cfg_data[AXIS_W-1:0];
                REG_CENTER_Y:     r_center_y     <= i_cfg_data[AXIS_W-1:0];
                REG_DEADZONE:     r_deadzone     <= i_cfg_data[DZ_W-1:0];
                REG_CONTROL:      r_control      <= i_cfg_data[CTL_W-1:0];
                REG_ACC_PEAK:     r_acc_peak     <= i_cfg_data[MAXF_W-1:0];
                REG_BRAKE_MAX:    r_brake_max    <= i_cfg_data[MAXF_W-1:0];
                REG_GAIN:         r_gain         <= i_cfg_data[SPEED_W-1:0];
                REG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[SCREEN_W-1:0];
                default:          r_control      <= r_control;
            endcase
        end
    end

    // dead zone radius squared, registered, so it follows the register in the next cycle
    always_ff @(posedge i_clk) begin
        r_dz2 <= (2*DZ_W)'(r_deadzone) * (2*DZ_W)'(r_deadzone);
    end

    // maxima below 1.0 count as 1.0, zero width counts as one pixel
    assign w_amax  = (AMW'(r_acc_peak) < ONE_A) ? ONE_A : AMW'(r_acc_peak);
    assign w_bmax  = (AMW'(r_brake_max) < ONE_A) ? ONE_A : AMW'(r_brake_max);
    assign w_width = (r_screen_width == '0) ? SCREEN_W'(1) : r_screen_width;

    // roots of the accel peak for the power curve
    stc_roots #(
        .FRAC_BITS (FRAC_BITS),
        .AMW       (AMW),
        .RW        (RW)
    ) u_roots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_amax_wr),
        .i_amax  (w_amax),
        .o_busy  (w_roots_busy),
        .o_roots (w_roots)
    );

    // ------------------------------------------------------------- handshake
    // every stage moves together; a held result stalls the whole pipeline
    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en && !w_roots_busy && !w_amax_wr;

    // ------------------------------------------- stage 0: centre and triggers
    assign w_lrole = r_control[CTL_LROLE_LSB +: 2];
    assign w_rrole = r_control[CTL_RROLE_LSB +: 2];

    // larger trigger of each role; role three acts as none
    always_comb begin
        w_t = '0;
        w_b = '0;
        if (w_lrole == ROLE_ACCEL && i_in.trig_l > w_t) w_t = i_in.trig_l;
        if (w_rrole == ROLE_ACCEL && i_in.trig_r > w_t) w_t = i_in.trig_r;
        if (w_lrole == ROLE_BRAKE && i_in.trig_l > w_b) w_b = i_in.trig_l;
        if (w_rrole == ROLE_BRAKE && i_in.trig_r > w_b) w_b = i_in.trig_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_en) begin
            r_s0.valid <= i_in.valid && i_in.ready && r_control[CTL_ON];
            r_s0.x     <= {i_in.stick_x[AXIS_W-1], i_in.stick_x}
                        - {r_center_x[AXIS_W-1], r_center_x};
            r_s0.y     <= {i_in.stick_y[AXIS_W-1], i_in.stick_y}
                        - {r_center_y[AXIS_W-1], r_center_y};
            r_s0.t     <= w_t;
            r_s0.b     <= w_b;
        end
    end

    // ---------------------------------- stage 1: squares and linear products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_en) begin
            r_s1.valid <= r_s0.valid;
            r_s1.x     <= r_s0.x;
            r_s1.y     <= r_s0.y;
            r_s1.t     <= r_s0.t;
            r_s1.xx    <= SQ_W'(r_s0.x) * SQ_W'(r_s0.x);
            r_s1.yy    <= SQ_W'(r_s0.y) * SQ_W'(r_s0.y);
            r_s1.lin_p <= LPW'(r_s0.t) * LPW'(w_amax - ONE_A);
            r_s1.brk_p <= LPW'(r_s0.b) * LPW'(w_bmax - ONE_A);
        end
    end

    // ------------------------- stage 2: dead zone test, divide by full scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (w_en) begin
            r_s2.valid <= r_s1.valid
                && (({1'b0, r_s1.xx} + {1'b0, r_s1.yy}) > (SQ_W + 1)'(r_dz2));
            r_s2.x     <= r_s1.x;
            r_s2.y     <= r_s1.y;
            r_s2.t     <= r_s1.t;
            r_s2.lin_m <= LMW'(r_s1.lin_p) * LMW'(DIV255_MUL);
            r_s2.brk_m <= LMW'(r_s1.brk_p) * LMW'(DIV255_MUL);
        end
    end

    // ---------------------- stage 3: linear factors, power curve start at 1.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex[0].valid <= 1'b0;
        end else if (w_en) begin
            r_ex[0].valid <= r_s2.valid;
            r_ex[0].x     <= r_s2.x;
            r_ex[0].y     <= r_s2.y;
            r_ex[0].e     <= N_ROOTS'(r_s2.t) * EXP_STEP;
            r_ex[0].tz    <= (r_s2.t == '0);
            r_ex[0].tf    <= (r_s2.t == TRIG_FULL);
            r_ex[0].lin   <= ONE_A + AMW'(r_s2.lin_m >> DIV255_SHIFT);
            r_ex[0].brk   <= ONE_A + AMW'(r_s2.brk_m >> DIV255_SHIFT);
            r_ex[0].acc   <= RW'(1) << Q_INT;
        end
    end

    // -------------------- power curve: one root multiply per exponent bit
    for (genvar j = 0; j < N_ROOTS; j++) begin : g_exp
        logic [2*RW-1:0] w_prod;

        assign w_prod = (2*RW)'(r_ex[j].acc) * (2*RW)'(w_roots[j]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ex[j+1].valid <= 1'b0;
            end else if (w_en) begin
                r_ex[j+1] <= r_ex[j];
                if (r_ex[j].e[N_ROOTS-1-j]) begin
                    r_ex[j+1].acc <= w_prod[RW+Q_INT-1:Q_INT];
                end
            end
        end
    end

    // ------------------- stage m1: pick accel, divisor, speed times deflection
    always_comb begin
        if (!r_control[CTL_EXP]) begin
            w_accel = r_ex[N_ROOTS].lin;
        end else if (r_ex[N_ROOTS].tz) begin
            w_accel = ONE_A;
        end else if (r_ex[N_ROOTS].tf) begin
            w_accel = w_amax;
        end else begin
            w_accel = r_ex[N_ROOTS].acc[RW-1:Q_INT-FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.valid <= 1'b0;
        end else if (w_en) begin
            r_m1.valid <= r_ex[N_ROOTS].valid;
            r_m1.bx    <= BW'($signed({1'b0, r_gain})) * BW'(r_ex[N_ROOTS].x);
            r_m1.by    <= BW'($signed({1'b0, r_gain})) * BW'(r_ex[N_ROOTS].y);
            r_m1.accel <= w_accel;
            r_m1.den   <= DW'(w_width) * DW'(r_ex[N_ROOTS].brk);
        end
    end

    // ------------------------------------------------- stage m2: numerators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2.valid <= 1'b0;
        end else if (w_en) begin
            r_m2.valid <= r_m1.valid;
            r_m2.num_x <= NW'(r_m1.bx) * NW'($signed({1'b0, r_m1.accel}));
            r_m2.num_y <= NW'(r_m1.by) * NW'($signed({1'b0, r_m1.accel}));
            r_m2.den   <= r_m1.den;
        end
    end

    // ------------------------------- quotient, saturation and output register
    stc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_m2.valid),
        .i_num_x  (r_m2.num_x),
        .i_num_y  (r_m2.num_y),
        .i_den    (r_m2.den),
        .o_valid  (w_out_valid),
        .o_move_x (o_out.move_x),
        .o_move_y (o_out.move_y)
    );

    assign o_out.valid = w_out_valid;

    // ------------------------------------------------------------ assertions
    a_roots_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> w_roots_busy)
        else $error("root pass not running after reset");

    a_amax_write_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_amax_wr |=> !i_in.ready)
        else $error("request taken while roots are recomputed");

    a_cursor_off_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !r_control[CTL_ON]) |=> !r_s0.valid)
        else $error("sample kept with cursor mode off");

    a_factors_at_least_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex[0].valid |-> (r_ex[0].lin >= ONE_A) && (r_ex[0].brk >= ONE_A))
        else $error("linear factor below 1.0");

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for stick_to_cursor_delta: random and corner stick
// samples under several register settings, moves predicted and compared
// ----------------------------------------------------------------------------

// expected cursor moves, predicted from the samples the block accepts
class move_scoreboard;
    logic signed [15:0] center_x, center_y;
    logic [14:0]        deadzone;
    logic [5:0]         control;
    logic [13:0]        acc_peak, brake_max, screen_width;
    logic [15:0]        gain;
    logic signed [15:0] exp_x[$];
    logic signed [15:0] exp_y[$];
    int                 errors;

    function new();
        center_x     = '0;
        center_y     = '0;
        deadzone     = stc_pkg::DEADZONE_RST;
        control      = stc_pkg::CONTROL_RST;
        acc_peak     = stc_pkg::ACC_PEAK_RST;
        brake_max    = stc_pkg::BRAKE_MAX_RST;
        gain         = stc_pkg::GAIN_RST;
        screen_width = stc_pkg::SCREEN_WIDTH_RST;
        errors       = 0;
    endfunction

    function void set_reg(stc_pkg::t_reg_idx idx, logic [15:0] val);
        case (idx)
            stc_pkg::REG_CENTER_X:     center_x = val;
            stc_pkg::REG_CENTER_Y:     center_y = val;
            stc_pkg::REG_DEADZONE:     deadzone = val[14:0];
            stc_pkg::REG_CONTROL:      control = val[5:0];
            stc_pkg::REG_ACC_PEAK:     acc_peak = val[13:0];
            stc_pkg::REG_BRAKE_MAX:    brake_max = val[13:0];
            stc_pkg::REG_GAIN:         gain = val;
            stc_pkg::REG_SCREEN_WIDTH: screen_width = val[13:0];
            default: ;
        endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // accel peak ^ (t/255) by repeated square roots
    function longint unsigned power_accel(longint unsigned amax, longint unsigned t);
        longint unsigned e, r, acc;
        if (t == 0) return 256;
        if (t >= 255) return amax;
        e = (t << 16) / 255;
        r = amax << 12;
        acc = 64'd1 << 20;
        for (int k = 1; k <= 16; k++) begin
            r = int_sqrt(r << 20);
            if ((e >> (16 - k)) & 1) acc = (acc * r) >> 20;
        end
        return acc >> 12;
    endfunction

    function logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function void note_sample(logic signed [15:0] sx, logic signed [15:0] sy,
                              logic [7:0] lt, logic [7:0] rt);
        longint x, y, num, den;
        longint unsigned t, b, amax, bmax, accel, brake, width;
        logic [1:0] lrole, rrole;
        x = longint'(sx) - longint'(center_x);
        y = longint'(sy) - longint'(center_y);
        lrole = control[1:0];
        rrole = control[3:2];
        t = 0;
        b = 0;
        if (!control[stc_pkg::CTL_ON]) return;
        if (x * x + y * y <= longint'(deadzone) * longint'(deadzone)) return;
        if (lrole == stc_pkg::ROLE_ACCEL && lt > t) t = lt;
        if (rrole == stc_pkg::ROLE_ACCEL && rt > t) t = rt;
        if (lrole == stc_pkg::ROLE_BRAKE && lt > b) b = lt;
        if (rrole == stc_pkg::ROLE_BRAKE && rt > b) b = rt;
        amax = acc_peak < 256 ? 256 : acc_peak;
        bmax = brake_max < 256 ? 256 : brake_max;
        if (control[stc_pkg::CTL_EXP]) accel = power_accel(amax, t);
        else accel = 256 + t * (amax - 256) / 255;
        brake = 256 + b * (bmax - 256) / 255;
        width = screen_width == 0 ? 1 : screen_width;
        den = longint'(width * brake);
        num = longint'(gain) * x * longint'(accel);
        exp_x.push_back(clamp16(num / den));
        num = longint'(gain) * y * longint'(accel);
        exp_y.push_back(clamp16(-(num / den)));
    endfunction

    function void check_move(logic signed [15:0] mx, logic signed [15:0] my);
        logic signed [15:0] ex, ey;
        if (exp_x.size() == 0) begin
            $display("%0t: unexpected move x=%0d y=%0d", $time, mx, my);
            errors++;
            return;
        end
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        if (mx !== ex) begin
            $display("%0t: move_x expected %0d actual %0d", $time, ex, mx);
            errors++;
        end
        if (my !== ey) begin
            $display("%0t: move_y expected %0d actual %0d", $time, ey, my);
            errors++;
        end
    endfunction

    function int pending();
        return exp_x.size();
    endfunction
endclass

module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    stc_in_if  in_ch();
    stc_out_if out_ch();

    move_scoreboard moves;

    // sink side controls: random stalls, one long hold-off, quiet tail
    bit quiet;
    bit long_hold_req;
    bit long_hold_done;
    int hold_left;

    stick_to_cursor_delta dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // hard limit, far above the slowest correct run
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done && hold_left == 0) begin
            long_hold_done <= 1'b1;
            hold_left <= 300;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 9);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor: accepted requests on both channels, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                moves.note_sample(in_ch.stick_x, in_ch.stick_y,
                                  in_ch.trig_l, in_ch.trig_r);
            if (out_ch.valid && out_ch.ready)
                moves.check_move(out_ch.move_x, out_ch.move_y);
        end
    end

    // all tasks start and end on a falling edge
    task automatic send_sample(logic [15:0] sx, logic [15:0] sy,
                               logic [7:0] lt, logic [7:0] rt);
        in_ch.valid   <= 1'b1;
        in_ch.stick_x <= sx;
        in_ch.stick_y <= sy;
        in_ch.trig_l  <= lt;
        in_ch.trig_r  <= rt;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_input(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic write_reg(stc_pkg::t_reg_idx idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        moves.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait out every expected move, then the latency of dropped samples
    task automatic drain();
        idle_input(1);
        while (moves.pending() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick16(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic random_setting();
        write_reg(stc_pkg::REG_CENTER_X,
                  $urandom_range(0, 3) == 0 ? pick16(16'h8000, 16'h7fff)
                                            : 16'($signed($urandom_range(0, 4000)) - 2000));
        write_reg(stc_pkg::REG_CENTER_Y,
                  $urandom_range(0, 3) == 0 ? pick16(16'h8000, 16'h7fff)
                                            : 16'($signed($urandom_range(0, 4000)) - 2000));
        case ($urandom_range(0, 7))
            0: write_reg(stc_pkg::REG_DEADZONE, 16'd0);
            1: write_reg(stc_pkg::REG_DEADZONE, 16'd32767);
            default: write_reg(stc_pkg::REG_DEADZONE, 16'($urandom_range(0, 8000)));
        endcase
        // cursor mode mostly on so that results are common
        write_reg(stc_pkg::REG_CONTROL,
                  16'({$urandom_range(0, 7) != 0, 5'($urandom_range(0, 31))}));
        write_reg(stc_pkg::REG_ACC_PEAK, pick16(16'd0, 16'd16383));
        write_reg(stc_pkg::REG_BRAKE_MAX, pick16(16'd0, 16'd16383));
        write_reg(stc_pkg::REG_GAIN, pick16(16'd0, 16'd65535));
        write_reg(stc_pkg::REG_SCREEN_WIDTH, pick16(16'd0, 16'd16383));
    endtask

    initial begin
        moves = new();
        quiet = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.stick_x = '0;
        in_ch.stick_y = '0;
        in_ch.trig_l = '0;
        in_ch.trig_r = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset setting, axis extremes, stick at rest inside the dead zone
        send_sample(16'h8000, 16'h8000, 8'd0, 8'd0);
        send_sample(16'h7fff, 16'h7fff, 8'd255, 8'd255);
        send_sample(16'h0000, 16'h0000, 8'd0, 8'd0);
        send_sample(16'h0001, 16'hffff, 8'd1, 8'd254);
        drain();

        // directed: left accel, right brake with the linear curve, then both accel with the power curve, saturation
        write_reg(stc_pkg::REG_ACC_PEAK, 16'd16383);
        write_reg(stc_pkg::REG_BRAKE_MAX, 16'd16383);
        write_reg(stc_pkg::REG_SCREEN_WIDTH, 16'd1);
        write_reg(stc_pkg::REG_GAIN, 16'd65535);
        write_reg(stc_pkg::REG_CONTROL, 16'b10_1001);
        send_sample(16'h7fff, 16'h8000, 8'd255, 8'd0);
        send_sample(16'h0003, 16'hfffd, 8'd255, 8'd255);
        send_sample(16'h0001, 16'h0000, 8'd128, 8'd17);
        drain();
        write_reg(stc_pkg::REG_CONTROL, 16'b11_0101);
        for (int t = 0; t < 256; t += 51)
            send_sample(16'h0100, 16'hff00, t[7:0], 8'($urandom));
        drain();
        // role three acts as none, small maxima, zero width, cursor mode off
        write_reg(stc_pkg::REG_ACC_PEAK, 16'd7);
        write_reg(stc_pkg::REG_BRAKE_MAX, 16'd0);
        write_reg(stc_pkg::REG_SCREEN_WIDTH, 16'd0);
        write_reg(stc_pkg::REG_GAIN, 16'd3);
        write_reg(stc_pkg::REG_CONTROL, 16'b10_1111);
        send_sample(16'h1234, 16'hedcb, 8'd200, 8'd100);
        drain();
        write_reg(stc_pkg::REG_CONTROL, 16'b10_0110);
        send_sample(16'h4321, 16'h0042, 8'd90, 8'd255);
        drain();
        write_reg(stc_pkg::REG_CONTROL, 16'b01_0101);
        send_sample(16'h7fff, 16'h7fff, 8'd255, 8'd255);
        drain();

        // random phases, a fresh setting each, the last one without idling
        for (int phase = 0; phase < 11; phase++) begin
            random_setting();
            if (phase == 2) long_hold_req = 1'b1;
            if (phase == 10) quiet = 1'b1;
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 4) == 0)
                    // near the centre, around the dead zone edge
                    send_sample(16'(moves.center_x + $signed($urandom_range(0, 20000)) - 10000),
                                16'(moves.center_y + $signed($urandom_range(0, 20000)) - 10000),
                                8'($urandom), 8'($urandom));
                else
                    send_sample(16'($urandom), 16'($urandom),
                                8'($urandom), 8'($urandom));
                if (!quiet && $urandom_range(0, 5) == 0)
                    idle_input($urandom_range(1, 10));
            end
            drain();
        end

        if (moves.errors == 0 && moves.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/stc_pkg.sv
rtl/core/stc_if.sv
rtl/core/stc_roots.sv
rtl/core/stc_div.sv
rtl/core/stick_to_cursor_delta.sv
test/tb.sv
